@@ sv/ppuf_pkg.sv @@
// Package: payload types and sequencer states for the persistent union-find.
`default_nettype none
package ppuf_pkg;
    localparam int NODES = 1024;

    localparam logic [1:0] OP_ROOT  = 2'd0;
    localparam logic [1:0] OP_SIZE  = 2'd1;
    localparam logic [1:0] OP_MERGE = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [9:0]  node_a;
        logic [9:0]  node_b;
        logic [31:0] time_point;
    } t_in;

    typedef struct packed {
        logic        merged;
        logic [31:0] time_now;
        logic [9:0]  root_node;
        logic [10:0] set_size;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_FRD, S_FCHK, S_RROOT, S_RCHK, S_HRD, S_HCHK,
        S_MB, S_MSZ, S_MCMP, S_MW, S_DONE, S_CLR
    } t_state;
endpackage
`default_nettype wire

@@ sv/partially_persistent_union_find_top.sv @@
// Top level: sequencer and node/record memories of the persistent union-find.
// Usage: pulse i_start with i_in while o_busy is low; the item is taken at
// that edge. One result appears on o_out for one cycle with o_done high;
// the receiver cannot stall it.
// Walk: root, size and merge operations walk parent links in a shared walk
// unit, each hop a memory read, then a compare. A size query then reads
// history records back from its root; a merge walks the roots of a and b;
// an unused code walks nothing. With union by size, a walk takes at most
// log2 NODES (10) hops. The result shows in the last busy cycle, and the
// next item can be taken in the cycle after it.
// Reset: synchronous active-low i_rst_n clears the time counter and record
// count, then a clearing pass over all NODES (1024) nodes sets every node to
// unlinked, no history and size one; o_busy stays high during that pass.
// Only one item is in flight; o_busy is high from acceptance to o_done.
`default_nettype none
module partially_persistent_union_find_top #(
    parameter int TIME_WIDTH = 32
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  ppuf_pkg::t_in    i_in,
    output logic             o_busy,
    output logic             o_done,
    output ppuf_pkg::t_out   o_out
);
    import ppuf_pkg::*;
    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int SW = NW + 1;
    localparam logic [TIME_WIDTH-1:0] TMAX = '1;

    // memories; m_latest holds NODES when a root has no history
    logic [TIME_WIDTH-1:0] m_ltime [NODES];
    logic [NW-1:0]         m_lpar  [NODES];
    logic                  m_linked[NODES];
    logic [SW-1:0]         m_csize [NODES];
    logic [SW-1:0]         m_latest[NODES];
    logic [TIME_WIDTH-1:0] m_rtime [NODES];
    logic [SW-1:0]         m_rsize [NODES];
    logic [SW-1:0]         m_rprev [NODES];

    t_state r_state, n_state;
    logic [1:0]            r_op;
    logic [NW-1:0]         r_b, r_x, r_rx;
    logic [NW-1:0]         r_clr;
    logic [TIME_WIDTH-1:0] r_t, r_now;
    logic [SW-1:0]         r_cnt, r_rec, r_sx, r_lat;
    logic                  r_phase;  // 0: walking a, 1: walking b (merge)
    logic [SW:0]           r_steps;
    t_out                  r_out;
    logic                  r_done;

    // registered reads
    logic [TIME_WIDTH-1:0] q_ltime, q_rtime;
    logic [NW-1:0]         q_lpar;
    logic [SW-1:0]         q_latest;
    logic [SW-1:0]         q_csize, q_rsize, q_rprev;
    logic                  q_linked;

    logic [NW-1:0] idx_a, idx_b;
    logic [NW-1:0] w_x, w_y;
    logic [SW-1:0] w_sx, w_sy;
    logic          w_hasrec;
    assign idx_a = NW'(32'(i_in.node_a) % NODES);
    assign idx_b = NW'(32'(i_in.node_b) % NODES);
    assign w_hasrec = (q_latest < SW'(NODES));

    // merge comparison: r_x is a's root (size q_csize), r_rx is b's root (size r_sx);
    // a's root survives a tie
    always_comb begin
        if (r_sx > q_csize) begin
            w_x = r_rx; w_y = r_x; w_sx = r_sx; w_sy = q_csize;
        end else begin
            w_x = r_x; w_y = r_rx; w_sx = q_csize; w_sy = r_sx;
        end
    end

    logic [NW-1:0] rd_node;
    logic [NW-1:0] rd_rec;
    always_comb begin
        rd_node = r_x;
        rd_rec  = r_rec[NW-1:0];
    end

    always_ff @(posedge i_clk) begin
        q_ltime  <= m_ltime[rd_node];
        q_lpar   <= m_lpar[rd_node];
        q_csize  <= m_csize[rd_node];
        q_latest <= m_latest[rd_node];
        q_linked <= m_linked[rd_node];
        q_rtime  <= m_rtime[rd_rec];
        q_rsize  <= m_rsize[rd_rec];
        q_rprev  <= m_rprev[rd_rec];
    end

    logic hop;
    assign hop = q_linked && !(r_t < q_ltime) && (r_steps < (SW+1)'(NODES));
    logic w_en;
    assign w_en = (r_state == S_MW) && (w_x != w_y);
    logic rec_en;
    assign rec_en = w_en && (r_cnt < SW'(NODES));

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            m_linked[r_clr] <= 1'b0;
            m_latest[r_clr] <= SW'(NODES);
            m_csize[r_clr]  <= SW'(1);
        end else begin
            if (w_en) begin
                m_csize[w_x]  <= w_sx + w_sy;
                m_ltime[w_y]  <= r_now;
                m_lpar[w_y]   <= w_x;
                m_linked[w_y] <= 1'b1;
            end
            if (rec_en) begin
                m_rtime[r_cnt[NW-1:0]] <= r_now;
                m_rsize[r_cnt[NW-1:0]] <= w_sx + w_sy;
                m_rprev[r_cnt[NW-1:0]] <= (w_x == r_x) ? q_latest : r_lat;
                m_latest[w_x]          <= r_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_now    <= '0;
            r_cnt    <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            case (r_state)
                S_CLR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    if (i_start) begin
                        r_op <= i_in.operation;
                        r_b <= idx_b; r_x <= idx_a;
                        r_phase <= 1'b0;
                        r_steps <= '0;
                        if (i_in.operation == OP_MERGE) begin
                            if (r_now != TMAX) r_now <= r_now + 1'b1;
                            r_t <= (r_now != TMAX) ? r_now + 1'b1 : r_now;
                        end else begin
                            r_t <= TIME_WIDTH'(i_in.time_point);
                        end
                    end
                end
                S_FCHK: begin
                    if (hop) begin
                        r_x <= q_lpar;
                        r_steps <= r_steps + 1'b1;
                    end
                end
                S_RCHK: begin
                    r_rec <= q_latest;
                    r_steps <= '0;
                end
                S_HCHK: begin
                    r_rec <= q_rprev;
                    r_steps <= r_steps + 1'b1;
                end
                S_MB: begin
                    r_rx <= r_x; r_x <= r_b; r_phase <= 1'b1; r_steps <= '0;
                end
                S_MSZ: begin
                    r_x <= r_rx; r_rx <= r_x;
                end
                S_MCMP: begin
                    r_sx  <= q_csize;
                    r_lat <= q_latest;
                end
                S_MW: begin
                    if (rec_en) r_cnt <= r_cnt + 1'b1;
                end
                default: ;
            endcase
            if (n_state == S_DONE) r_done <= 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_out.merged    <= 1'b0;
            r_out.time_now  <= 32'(r_now);
            r_out.root_node <= '0;
            r_out.set_size  <= '0;
        end
        case (r_state)
            S_FCHK: if (!hop && r_op == OP_ROOT) r_out.root_node <= 10'(r_x);
            S_RCHK: if (!w_hasrec) r_out.set_size <= 11'(1);
            S_HRD: if (r_rec >= SW'(NODES) || r_steps >= (SW+1)'(NODES))
                r_out.set_size <= 11'(1);
            S_HCHK: if (q_rtime <= r_t) r_out.set_size <= 11'(q_rsize);
            S_MW: r_out.merged <= (w_x != w_y);
            default: ;
        endcase
        if (n_state == S_DONE && r_state != S_IDLE) r_out.time_now <= 32'(r_now);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: if (r_clr == NW'(NODES - 1)) n_state = S_IDLE;
            S_IDLE: if (i_start) begin
                if (i_in.operation inside {OP_ROOT, OP_SIZE, OP_MERGE}) n_state = S_FRD;
                else n_state = S_DONE;
            end
            S_FRD: n_state = S_FCHK;
            S_FCHK: begin
                if (hop) n_state = S_FRD;
                else if (r_op == OP_ROOT) n_state = S_DONE;
                else if (r_op == OP_SIZE) n_state = S_RROOT;
                else if (!r_phase) n_state = S_MB;
                else n_state = S_MSZ;
            end
            S_RROOT: n_state = S_RCHK;
            S_RCHK: n_state = w_hasrec ? S_HRD : S_DONE;
            S_HRD: begin
                if (r_rec >= SW'(NODES) || r_steps >= (SW+1)'(NODES)) n_state = S_DONE;
                else n_state = S_HCHK;
            end
            S_HCHK: n_state = (q_rtime <= r_t) ? S_DONE : S_HRD;
            S_MB: n_state = S_FRD;
            // read size of b's root (r_x) is q_csize now; park it, then reread a's
            S_MSZ: n_state = S_MCMP;
            S_MCMP: n_state = S_MW;
            S_MW: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_out  = r_out;

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy) else $error("busy after done");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= SW'(NODES)) else $error("record count overflow");
`endif
endmodule
`default_nettype wire
